/* rtl/nonlinear_pose_smoothing_filter_macros.svh */
// ----------------------------------------------------------------------------
// nonlinear_pose_smoothing_filter_macros
// assertion macros used by the pose smoothing filter rtl
// ----------------------------------------------------------------------------
`ifndef NONLINEAR_POSE_SMOOTHING_FILTER_MACROS_SVH
`define NONLINEAR_POSE_SMOOTHING_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define NPSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define NPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NPSF_ASSERT_NOW(lbl, ante, cons, msg)
`define NPSF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/npsf_pkg.sv */
// ----------------------------------------------------------------------------
// npsf_pkg
// constants of the pose smoothing filter
// ----------------------------------------------------------------------------
`default_nettype none

package npsf_pkg;

  localparam int NPSF_CHANNELS   = 6;
  localparam int NPSF_TZ_LANE    = 5;
  localparam int NPSF_FACTOR_W   = 24;
  localparam int NPSF_FACTOR_FRAC = 16;
  localparam int NPSF_TZ_SHIFT   = 2;   // tz uses four times the factor
  localparam int NPSF_FRAME_W    = 32;

  localparam logic [NPSF_FACTOR_W-1:0] NPSF_FACTOR_RESET = 24'd65536;

  typedef logic [2:0] npsf_state_t;

endpackage

`default_nettype wire

/* rtl/nonlinear_pose_smoothing_filter.sv */
// ----------------------------------------------------------------------------
// nonlinear_pose_smoothing_filter
// six-channel adaptive nonlinear smoothing of a pose frame, bit-serial
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready) takes one raw pose frame; out channel
//   (out_valid/out_ready) returns the six filtered values and the frame number
//   each channel stores y' = y + sign(d) * floor(|d|^2 / (|d| + k)), d = x - y, with 4k for k on tz
//   cfg_wr_en/cfg_wr_data write the smoothing factor k (unsigned q8.16);
//   write it only while the block is idle
// timing:
//   six lanes run side by side; each squares |d| one multiplier bit per cycle
//   and then divides one quotient bit per cycle; an accepted item passes
//   through the delta, multiply, divide and done states in that order, and
//   the block takes no new item until the last one has left the done state
//   in_ready is high only while no item is being worked on
// stall: the result sits in the output register; the next item may be taken
//   and computed meanwhile, it then waits until the output register is free
// reset: filtered values clear to zero, factor returns to 1.0, out_valid low
// ----------------------------------------------------------------------------
`default_nettype none

`include "nonlinear_pose_smoothing_filter_macros.svh"

module nonlinear_pose_smoothing_filter
  import npsf_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [NPSF_FACTOR_W-1:0]        cfg_wr_data,
  // input items
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0]   raw_heading,
  input  wire logic signed [VALUE_WIDTH-1:0]   raw_pitch,
  input  wire logic signed [VALUE_WIDTH-1:0]   raw_roll,
  input  wire logic signed [VALUE_WIDTH-1:0]   raw_shift_x,
  input  wire logic signed [VALUE_WIDTH-1:0]   raw_shift_y,
  input  wire logic signed [VALUE_WIDTH-1:0]   raw_shift_z,
  input  wire logic [NPSF_FRAME_W-1:0]         frame_number,
  // result items
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [VALUE_WIDTH-1:0]        smooth_heading,
  output logic signed [VALUE_WIDTH-1:0]        smooth_pitch,
  output logic signed [VALUE_WIDTH-1:0]        smooth_roll,
  output logic signed [VALUE_WIDTH-1:0]        smooth_shift_x,
  output logic signed [VALUE_WIDTH-1:0]        smooth_shift_y,
  output logic signed [VALUE_WIDTH-1:0]        smooth_shift_z,
  output logic [NPSF_FRAME_W-1:0]              frame_number_out
);

  localparam int W   = VALUE_WIDTH;
  // factor alignment to FRAC_BITS fraction bits
  localparam int SHL = (FRAC_BITS > NPSF_FACTOR_FRAC) ? FRAC_BITS - NPSF_FACTOR_FRAC : 0;
  localparam int SHR = (FRAC_BITS < NPSF_FACTOR_FRAC) ? NPSF_FACTOR_FRAC - FRAC_BITS : 0;
  localparam int KW  = NPSF_FACTOR_W + NPSF_TZ_SHIFT + SHL;
  // divisor width: holds |d| + k without overflow
  localparam int DW  = ((W > KW) ? W : KW) + 1;
  localparam int CW  = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  // sequencer states
  localparam npsf_state_t ST_IDLE  = 3'd0;
  localparam npsf_state_t ST_DELTA = 3'd1;
  localparam npsf_state_t ST_MUL   = 3'd2;
  localparam npsf_state_t ST_DIV   = 3'd3;
  localparam npsf_state_t ST_DONE  = 3'd4;

  npsf_state_t state;
  logic [CW-1:0] cnt;

  logic [NPSF_FACTOR_W-1:0] factor;
  logic [KW-1:0]            k_al;
  logic [KW-1:0]            kz_al;

  // per-lane registers
  logic [W-1:0]  filt  [NPSF_CHANNELS];  // stored filtered value
  logic [W-1:0]  xin   [NPSF_CHANNELS];  // captured raw value
  logic          neg   [NPSF_CHANNELS];  // sign of delta
  logic [W-1:0]  mag   [NPSF_CHANNELS];  // |delta|, multiplicand
  logic [W-1:0]  hi    [NPSF_CHANNELS];  // upper product half
  logic [W-1:0]  lo    [NPSF_CHANNELS];  // multiplier, low product, quotient
  logic [DW-1:0] rem   [NPSF_CHANNELS];  // partial remainder
  logic [DW-1:0] dvs   [NPSF_CHANNELS];  // divisor |delta| + k, 4k on tz
  logic          dz    [NPSF_CHANNELS];  // divisor is zero
  logic [NPSF_FRAME_W-1:0] frame_reg;

  // per-lane combinational terms
  logic [W-1:0]  raw_arr   [NPSF_CHANNELS];
  logic [W:0]    delta_c   [NPSF_CHANNELS];
  logic [W-1:0]  mag_c     [NPSF_CHANNELS];
  logic [DW-1:0] dvs_c     [NPSF_CHANNELS];
  logic [W:0]    psum_c    [NPSF_CHANNELS];
  logic [DW:0]   r2_c      [NPSF_CHANNELS];
  logic [DW:0]   rdiff_c   [NPSF_CHANNELS];
  logic          qbit_c    [NPSF_CHANNELS];
  logic [W-1:0]  step_c    [NPSF_CHANNELS];
  logic [W-1:0]  newv_c    [NPSF_CHANNELS];

  logic in_fire;
  logic out_load;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  // result moves into the output register once it is free or being drained
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // aligned factors; tz takes the product before alignment
  assign k_al  = (KW'(factor) << SHL) >> SHR;
  assign kz_al = ((KW'(factor) << NPSF_TZ_SHIFT) << SHL) >> SHR;

  assign raw_arr[0] = raw_heading;
  assign raw_arr[1] = raw_pitch;
  assign raw_arr[2] = raw_roll;
  assign raw_arr[3] = raw_shift_x;
  assign raw_arr[4] = raw_shift_y;
  assign raw_arr[5] = raw_shift_z;

  always_comb begin
    for (int i = 0; i < NPSF_CHANNELS; i++) begin
      // delta and magnitude, one bit wider to keep the sign
      delta_c[i] = {xin[i][W-1], xin[i]} - {filt[i][W-1], filt[i]};
      mag_c[i]   = delta_c[i][W] ? W'(-delta_c[i]) : delta_c[i][W-1:0];
      dvs_c[i]   = DW'(mag_c[i]) + ((i == NPSF_TZ_LANE) ? DW'(kz_al) : DW'(k_al));
      // shift-add square step: add multiplicand when multiplier bit is set
      psum_c[i]  = {1'b0, hi[i]} + (lo[i][0] ? {1'b0, mag[i]} : '0);
      // restoring divide step: bring in the next numerator bit
      r2_c[i]    = {rem[i], lo[i][W-1]};
      rdiff_c[i] = r2_c[i] - {1'b0, dvs[i]};
      qbit_c[i]  = (r2_c[i] >= {1'b0, dvs[i]});
      // zero divisor gives zero gain
      step_c[i]  = dz[i] ? '0 : lo[i];
      newv_c[i]  = neg[i] ? (filt[i] - step_c[i]) : (filt[i] + step_c[i]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      factor    <= NPSF_FACTOR_RESET;
    end else begin
      if (cfg_wr_en) begin
        factor <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // filtered state, reset to zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < NPSF_CHANNELS; i++) begin
      if (rst) begin
        filt[i] <= '0;
      end else if (out_load) begin
        filt[i] <= newv_c[i];
      end
    end
  end

  // lane datapath
  always_ff @(posedge clk) begin
    for (int i = 0; i < NPSF_CHANNELS; i++) begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            xin[i] <= raw_arr[i];
          end
        end
        ST_DELTA: begin
          neg[i] <= delta_c[i][W];
          mag[i] <= mag_c[i];
          dvs[i] <= dvs_c[i];
          dz[i]  <= (dvs_c[i] == '0);
          hi[i]  <= '0;
          lo[i]  <= mag_c[i];
        end
        ST_MUL: begin
          hi[i] <= psum_c[i][W:1];
          lo[i] <= {psum_c[i][0], lo[i][W-1:1]};
          // on the last bit the upper product half seeds the remainder
          if (cnt == CNT_LAST) begin
            rem[i] <= DW'(psum_c[i][W:1]);
          end
        end
        ST_DIV: begin
          rem[i] <= qbit_c[i] ? rdiff_c[i][DW-1:0] : r2_c[i][DW-1:0];
          lo[i]  <= {lo[i][W-2:0], qbit_c[i]};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_reg <= frame_number;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      smooth_heading   <= newv_c[0];
      smooth_pitch     <= newv_c[1];
      smooth_roll      <= newv_c[2];
      smooth_shift_x   <= newv_c[3];
      smooth_shift_y   <= newv_c[4];
      smooth_shift_z   <= newv_c[5];
      frame_number_out <= frame_reg;
    end
  end

  // an accepted item always starts the delta step
  `NPSF_ASSERT_NEXT(a_fire_to_delta, in_fire, state == ST_DELTA, "item not started")
  // output register takes the value that became the stored state
  `NPSF_ASSERT_NEXT(a_out_matches_state, out_load,
                    out_valid && smooth_heading == filt[0] && smooth_shift_z == filt[5],
                    "output differs from stored state")
  // tz lane partial remainder stays below the divisor unless the divisor is zero
  `NPSF_ASSERT_NOW(a_rem_bound, state == ST_DIV, dz[NPSF_TZ_LANE] || rem[NPSF_TZ_LANE] < dvs[NPSF_TZ_LANE],
                   "remainder out of range")

endmodule

`default_nettype wire
